FILE: src/bwoe_pkg.sv
// ----------------------------------------------------------------------------
// bwoe_pkg
// Operation codes, field widths and limits shared by the bitset word engine
// and its checker.
// ----------------------------------------------------------------------------
package bwoe_pkg;

  localparam int WORD_W    = 32;
  localparam int KIND_W    = 4;
  localparam int ITEM_W    = 26;
  localparam int COUNT_W   = ITEM_W + 1;
  localparam int POP_W     = $clog2(WORD_W + 1);
  localparam int END_W     = $clog2(WORD_W);

  // in_tuser: kind, is_first
  localparam int IN_USER_W = KIND_W + 1;
  // in_tdata: word_a, word_b
  localparam int IN_DATA_W = 2 * WORD_W;

  // out_tdata: result_word, other_word_out, new_bits_word, run_flag, run_count
  localparam int OUT_FIELD_W = 3 * WORD_W + 1 + COUNT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  localparam int OFS_OTHER = WORD_W;
  localparam int OFS_NEW   = 2 * WORD_W;
  localparam int OFS_FLAG  = 3 * WORD_W;
  localparam int OFS_COUNT = 3 * WORD_W + 1;

  localparam logic [COUNT_W-1:0] TALLY_MAX = COUNT_W'(1) << ITEM_W;
  localparam logic [WORD_W-1:0]  FULL_WORD = '1;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_UNION    = 4'd0;
  localparam kind_t KIND_AND      = 4'd1;
  localparam kind_t KIND_DIFF     = 4'd2;
  localparam kind_t KIND_NOR      = 4'd3;
  localparam kind_t KIND_MERGE    = 4'd4;
  localparam kind_t KIND_ENSURE   = 4'd5;
  localparam kind_t KIND_EQUAL    = 4'd6;
  localparam kind_t KIND_SUBSET   = 4'd7;
  localparam kind_t KIND_DISJOINT = 4'd8;
  localparam kind_t KIND_COUNT    = 4'd9;
  localparam kind_t KIND_FILL     = 4'd10;
  localparam kind_t KIND_CLEAR    = 4'd11;

endpackage

FILE: src/bitset_word_operation_engine_unit.sv
// ----------------------------------------------------------------------------
// bitset_word_operation_engine_unit
// Applies a set operation to one word pair of two dense bitsets per request.
//
// One request per cycle is taken, as long as the output is not stalled,
// and one result per request is given: the request lands in an input
// register, and a single pass of bitwise logic, a 32-bit
// popcount and a 27-bit saturating add fills the result register. Running
// flag and count are carried from word to word of a run and restart after
// the word marked last. item_count sets the padding mask used by fill on the
// last word; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module bitset_word_operation_engine_unit
  import bwoe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: item_count
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ITEM_W-1:0]     cfg_data,
  // requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // word_a, word_b
  input  logic [IN_USER_W-1:0]  in_tuser,   // kind, is_first
  input  logic                  in_tlast,   // is_last
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_word, other_word_out,
                                            // new_bits_word, run_flag,
                                            // run_count, zero pad
  output logic                  out_tlast   // last_out
);

  function automatic logic [POP_W-1:0] pop_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] p1, p2, p3, p4, p5;
    p1 = (w & 32'h5555_5555) + ((w >> 1) & 32'h5555_5555);
    p2 = (p1 & 32'h3333_3333) + ((p1 >> 2) & 32'h3333_3333);
    p3 = (p2 & 32'h0F0F_0F0F) + ((p2 >> 4) & 32'h0F0F_0F0F);
    p4 = (p3 & 32'h00FF_00FF) + ((p3 >> 8) & 32'h00FF_00FF);
    p5 = (p4 & 32'h0000_FFFF) + ((p4 >> 16) & 32'h0000_FFFF);
    return p5[POP_W-1:0];
  endfunction

  logic [ITEM_W-1:0]  item_count_r;

  logic               s1_valid_r;
  kind_t              s1_kind_r;
  logic [WORD_W-1:0]  s1_a_r;
  logic [WORD_W-1:0]  s1_b_r;
  logic               s1_first_r;
  logic               s1_last_r;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic               out_last_r;

  logic               seen_r;
  logic               seen_nxt;
  logic [COUNT_W-1:0] tally_r;
  logic [COUNT_W-1:0] tally_nxt;

  logic               s2_ready;
  logic               s1_adv;

  logic [WORD_W-1:0]  res_w, other_w, fresh_w, fill_w, last_mask;
  logic               flag_w, broken;
  logic [COUNT_W-1:0] count_w, tally_sum;
  logic [ITEM_W-1:0]  item_end;
  logic [END_W-1:0]   end_bits;

  assign cfg_ready  = 1'b1;
  assign s2_ready   = !out_valid_r || out_tready;
  assign s1_adv     = s1_valid_r && s2_ready;
  assign in_tready  = !s1_valid_r || s2_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Valid bits in the last word: (item_count + 1) mod word size, zero = full.
  assign item_end  = item_count_r + ITEM_W'(1);
  assign end_bits  = item_end[END_W-1:0];
  assign last_mask = (end_bits == '0) ? FULL_WORD : ~(FULL_WORD << end_bits);
  assign tally_sum = tally_r + COUNT_W'(pop_word(s1_a_r));

  always_comb begin
    fill_w = FULL_WORD;
    if (s1_last_r) begin
      fill_w = fill_w & last_mask;
    end
    if (s1_first_r) begin
      fill_w = fill_w & ~WORD_W'(1);
    end
  end

  always_comb begin
    res_w     = s1_a_r;
    other_w   = s1_b_r;
    fresh_w   = '0;
    flag_w    = 1'b0;
    count_w   = '0;
    seen_nxt  = seen_r;
    tally_nxt = tally_r;
    broken    = 1'b0;
    case (s1_kind_r)
      KIND_UNION: res_w = s1_a_r | s1_b_r;
      KIND_AND:   res_w = s1_a_r & s1_b_r;
      KIND_DIFF:  res_w = s1_a_r & ~s1_b_r;
      KIND_NOR:   res_w = ~(s1_a_r | s1_b_r);
      KIND_MERGE, KIND_ENSURE: begin
        fresh_w = s1_b_r & ~s1_a_r;
        res_w   = s1_a_r | s1_b_r;
        if (s1_kind_r == KIND_MERGE) begin
          other_w = '0;
        end
        seen_nxt = seen_r || (fresh_w != '0);
        flag_w   = seen_nxt;
      end
      KIND_EQUAL, KIND_SUBSET, KIND_DISJOINT: begin
        if (s1_kind_r == KIND_EQUAL) begin
          broken = (s1_a_r != s1_b_r);
        end else if (s1_kind_r == KIND_SUBSET) begin
          broken = ((s1_a_r & ~s1_b_r) != '0);
        end else begin
          broken = ((s1_a_r & s1_b_r) != '0);
        end
        seen_nxt = seen_r || broken;
        flag_w   = !seen_nxt;
      end
      KIND_COUNT: begin
        tally_nxt = (tally_sum > TALLY_MAX) ? TALLY_MAX : tally_sum;
        count_w   = tally_nxt;
      end
      KIND_FILL:  res_w = fill_w;
      KIND_CLEAR: res_w = '0;
      default: ;
    endcase
    // restart the run after its last word
    if (s1_last_r) begin
      seen_nxt  = 1'b0;
      tally_nxt = '0;
    end
    out_data_nxt = {{OUT_PAD_W{1'b0}}, count_w, flag_w, fresh_w, other_w, res_w};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      seen_r       <= 1'b0;
      tally_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        item_count_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        seen_r  <= seen_nxt;
        tally_r <= tally_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r  <= in_tuser[KIND_W-1:0];
      s1_first_r <= in_tuser[KIND_W];
      s1_a_r     <= in_tdata[WORD_W-1:0];
      s1_b_r     <= in_tdata[IN_DATA_W-1:WORD_W];
      s1_last_r  <= in_tlast;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      out_last_r <= s1_last_r;
    end
  end

endmodule

FILE: src/bwoe_checker.sv
// ----------------------------------------------------------------------------
// bwoe_checker
// Port-level checks for the bitset word engine, bound to its top level.
// ----------------------------------------------------------------------------
module bwoe_checker
  import bwoe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic [WORD_W-1:0]  res_f;
  logic [WORD_W-1:0]  new_f;
  logic [COUNT_W-1:0] cnt_f;

  assign res_f = out_tdata[WORD_W-1:0];
  assign new_f = out_tdata[OFS_NEW +: WORD_W];
  assign cnt_f = out_tdata[OFS_COUNT +: COUNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with an empty output");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_f <= TALLY_MAX)
    else $error("running count above saturation");

  a_new_in_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (new_f & ~res_f) == '0)
    else $error("new bits missing from result word");

endmodule

bind bitset_word_operation_engine_unit bwoe_checker u_bwoe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: dv/tb_bitset_word_operation_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_bitset_word_operation_engine_unit
// Self-checking bench for the bitset word engine. Each accepted request is
// run through a local model of the set operations. The model carries the
// running flag, the running tally and item_count. Every result from the
// engine is compared field by field with the oldest prediction. Stimulus is
// a directed pass, fill words under four item_count settings, random runs
// under five with random idle bursts on both sides, then a full-rate stream.
// ----------------------------------------------------------------------------
module tb_bitset_word_operation_engine_unit;
  import bwoe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    CYCLE_LIMIT      = 200_000;
  localparam int    RANDOM_PHASE_LEN = 80;
  localparam int    SHOW_LIMIT       = 40;
  localparam kind_t KIND_SPARE_FIRST = KIND_CLEAR + 4'd1;
  localparam logic [ITEM_W-1:0] ITEMS_MAX = '1;

  // how word_b relates to word_a within a run
  typedef enum int {
    REL_EQUAL, REL_SUPERSET, REL_DISJOINT, REL_FLIP, REL_SUBSET, REL_RANDOM
  } pair_rel_t;

  typedef struct packed {
    logic [WORD_W-1:0]  result_word;
    logic [WORD_W-1:0]  other_word;
    logic [WORD_W-1:0]  new_bits;
    logic               run_flag;
    logic [COUNT_W-1:0] run_count;
    logic               last_out;
  } word_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [ITEM_W-1:0]     cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // word_a, word_b
  logic [IN_USER_W-1:0]  in_tuser   = '0;  // kind, is_first
  logic                  in_tlast   = 1'b0; // is_last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // result_word, other_word_out,
                                     // new_bits_word, run_flag, run_count, pad
  logic                  out_tlast;  // last_out

  // model state
  logic              run_seen  = 1'b0;
  int unsigned       run_tally = 0;
  logic [ITEM_W-1:0] set_items = '0;

  word_result_t pending_words[$];
  int           fail_count    = 0;
  int           words_sent    = 0;
  int           config_writes = 0;
  int           cycle_count   = 0;
  int           stall_left    = 0;
  bit           quiet         = 1'b0;

  bitset_word_operation_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_words.size());
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic word_result_t apply_word_op(input kind_t kind,
                                                 input logic [WORD_W-1:0] word_a, word_b,
                                                 input logic is_first, is_last);
    word_result_t r;
    logic         broken;
    int unsigned  end_bit;
    r.result_word = word_a;
    r.other_word  = word_b;
    r.new_bits    = '0;
    r.run_flag    = 1'b0;
    r.run_count   = '0;
    r.last_out    = is_last;
    case (kind)
      KIND_UNION: r.result_word = word_a | word_b;
      KIND_AND:   r.result_word = word_a & word_b;
      KIND_DIFF:  r.result_word = word_a & ~word_b;
      KIND_NOR:   r.result_word = ~(word_a | word_b);
      KIND_MERGE, KIND_ENSURE: begin
        r.new_bits    = word_b & ~word_a;
        r.result_word = word_a | word_b;
        if (kind == KIND_MERGE) r.other_word = '0;
        if (r.new_bits != '0) run_seen = 1'b1;
        r.run_flag = run_seen;
      end
      KIND_EQUAL, KIND_SUBSET, KIND_DISJOINT: begin
        if (kind == KIND_EQUAL)       broken = (word_a != word_b);
        else if (kind == KIND_SUBSET) broken = ((word_a & ~word_b) != '0);
        else                          broken = ((word_a & word_b) != '0);
        if (broken) run_seen = 1'b1;
        r.run_flag = ~run_seen;
      end
      KIND_COUNT: begin
        run_tally = run_tally + $countones(word_a);
        if (run_tally > TALLY_MAX) run_tally = TALLY_MAX;
        r.run_count = run_tally[COUNT_W-1:0];
      end
      KIND_FILL: begin
        r.result_word = FULL_WORD;
        if (is_last) begin
          end_bit = (set_items + 1) % WORD_W;
          if (end_bit != 0) r.result_word &= (32'h1 << end_bit) - 32'h1;
        end
        if (is_first) r.result_word[0] = 1'b0;
      end
      KIND_CLEAR: r.result_word = '0;
      default: ;
    endcase
    // every kind ends the run on the last word
    if (is_last) begin
      run_seen  = 1'b0;
      run_tally = 0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want, got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
        $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    word_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("%0t unexpected result: expected none actual %h", $time, out_tdata);
      end else begin
        want = pending_words.pop_front();
        check_field("result_word", want.result_word, out_tdata[OFS_OTHER-1:0]);
        check_field("other_word_out", want.other_word, out_tdata[OFS_NEW-1:OFS_OTHER]);
        check_field("new_bits_word", want.new_bits, out_tdata[OFS_FLAG-1:OFS_NEW]);
        check_field("run_flag", WORD_W'(want.run_flag), WORD_W'(out_tdata[OFS_FLAG]));
        check_field("run_count", WORD_W'(want.run_count),
                    WORD_W'(out_tdata[OFS_COUNT+COUNT_W-1:OFS_COUNT]));
        check_field("last_out", WORD_W'(want.last_out), WORD_W'(out_tlast));
      end
    end
  end

  // valid stays high across back-to-back requests; drop it only for a gap
  task automatic send_word(input kind_t kind, input logic [WORD_W-1:0] word_a, word_b,
                           input logic is_first, is_last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {word_b, word_a};
    in_tuser  <= {is_first, kind};
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    pending_words.push_back(apply_word_op(kind, word_a, word_b, is_first, is_last));
    words_sent++;
  endtask

  // hold requests and let the engine drain before touching the register
  task automatic write_item_count(input logic [ITEM_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_items = value;
    config_writes++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'h1 << $urandom_range(0, WORD_W - 1);
      3:       w = ~(32'h1 << $urandom_range(0, WORD_W - 1));
      default: w = $urandom();
    endcase
    return w;
  endfunction

  function automatic logic [2*WORD_W-1:0] pick_pair(input pair_rel_t rel);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = pick_word();
    case (rel)
      REL_EQUAL:    b = a;
      REL_SUPERSET: b = a | $urandom();
      REL_DISJOINT: b = ~a & $urandom();
      REL_FLIP: begin
        b = a;
        b[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
      end
      REL_SUBSET:   b = a & $urandom();
      default:      b = pick_word();
    endcase
    return {b, a};
  endfunction

  // one well-formed run: word zero flagged first, final word flagged last
  task automatic send_run(input int len, input bit mixed);
    kind_t             kind;
    pair_rel_t         rel;
    logic [2*WORD_W-1:0] pair;
    kind = ($urandom_range(0, 9) == 0) ? kind_t'($urandom_range(KIND_SPARE_FIRST, 15))
                                       : kind_t'($urandom_range(KIND_UNION, KIND_CLEAR));
    rel  = pair_rel_t'($urandom_range(REL_EQUAL, REL_RANDOM));
    for (int i = 0; i < len; i++) begin
      if (mixed && $urandom_range(0, 2) == 0) kind = kind_t'($urandom_range(0, 15));
      pair = ($urandom_range(0, 6) == 0) ? pick_pair(REL_RANDOM) : pick_pair(rel);
      send_word(kind, pair[WORD_W-1:0], pair[2*WORD_W-1:WORD_W], i == 0, i == len - 1);
    end
  endtask

  task automatic send_random_traffic(input int target);
    int start;
    start = words_sent;
    while (words_sent - start < target) begin
      if ($urandom_range(0, 6) != 0) begin
        send_run($urandom_range(1, 8), $urandom_range(0, 4) == 0);
      end else begin
        // broken framing: random first and last flags
        repeat ($urandom_range(1, 3))
          send_word(kind_t'($urandom_range(0, 15)), $urandom(), $urandom(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_directed_ops();
    // item_count is still at its reset value here
    send_word(KIND_UNION, 32'h0, 32'h0, 1'b1, 1'b1);
    send_word(KIND_UNION, 32'hFFFF_0000, 32'h0000_FFFF, 1'b1, 1'b1);
    send_word(KIND_AND, FULL_WORD, FULL_WORD, 1'b1, 1'b1);
    send_word(KIND_AND, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1);
    send_word(KIND_DIFF, FULL_WORD, 32'h0, 1'b1, 1'b1);
    send_word(KIND_DIFF, FULL_WORD, FULL_WORD, 1'b1, 1'b1);
    // nor leaves bit 0 and the padding set
    send_word(KIND_NOR, 32'h0, 32'h0, 1'b1, 1'b1);
    send_word(KIND_NOR, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1);
    // merge run: flag rises on word zero and stays up
    send_word(KIND_MERGE, 32'h0000_00F0, 32'h0000_000F, 1'b1, 1'b0);
    send_word(KIND_MERGE, FULL_WORD, FULL_WORD, 1'b0, 1'b0);
    send_word(KIND_MERGE, 32'h0, 32'h0, 1'b0, 1'b1);
    send_word(KIND_ENSURE, FULL_WORD, 32'h1234_5678, 1'b1, 1'b1);
    send_word(KIND_ENSURE, 32'h0, FULL_WORD, 1'b1, 1'b1);
    // equal holds then breaks
    send_word(KIND_EQUAL, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1, 1'b0);
    send_word(KIND_EQUAL, 32'hDEAD_BEEF, 32'hDEAD_BEEE, 1'b0, 1'b1);
    send_word(KIND_SUBSET, 32'h3, 32'h7, 1'b1, 1'b1);
    send_word(KIND_SUBSET, 32'h8, 32'h7, 1'b1, 1'b1);
    send_word(KIND_DISJOINT, 32'hF0, 32'h0F, 1'b1, 1'b1);
    send_word(KIND_DISJOINT, FULL_WORD, 32'h8000_0000, 1'b1, 1'b1);
    // count run with a spare kind in the middle sharing the tally
    send_word(KIND_COUNT, FULL_WORD, 32'h0, 1'b1, 1'b0);
    send_word(KIND_SPARE_FIRST, 32'h1357_9BDF, 32'h2468_ACE0, 1'b0, 1'b0);
    send_word(KIND_COUNT, 32'h8000_0001, FULL_WORD, 1'b0, 1'b1);
    // merge then equal in one run: equal sees the merge flag as broken
    send_word(KIND_MERGE, 32'h0, 32'h1, 1'b1, 1'b0);
    send_word(KIND_EQUAL, 32'h5, 32'h5, 1'b0, 1'b1);
    // fill on a single word takes both the padding mask and bit 0
    send_word(KIND_FILL, 32'h0, 32'h0, 1'b1, 1'b1);
    send_word(KIND_FILL, 32'h0, 32'h0, 1'b1, 1'b0);
    send_word(KIND_FILL, 32'h0, 32'h0, 1'b0, 1'b0);
    send_word(KIND_CLEAR, FULL_WORD, FULL_WORD, 1'b0, 1'b1);
    for (int n = 1; n < 4; n++)
      send_word(KIND_SPARE_FIRST + kind_t'(n), $urandom(), $urandom(), 1'b1, 1'b1);
  endtask

  task automatic test_item_count_masks();
    logic [ITEM_W-1:0] widths[4];
    widths = '{ITEM_W'(30), ITEM_W'(31), ITEMS_MAX - 1'b1, ITEMS_MAX};
    foreach (widths[i]) begin
      write_item_count(widths[i]);
      send_word(KIND_FILL, $urandom(), $urandom(), 1'b0, 1'b1);
      send_word(KIND_FILL, $urandom(), $urandom(), 1'b1, 1'b1);
    end
  endtask

  task automatic test_random_runs();
    logic [ITEM_W-1:0] settings[5];
    settings = '{ITEM_W'($urandom()), ITEM_W'(0), ITEM_W'(31), ITEMS_MAX,
                 ITEM_W'($urandom_range(0, 100))};
    foreach (settings[i]) begin
      write_item_count(settings[i]);
      send_random_traffic(RANDOM_PHASE_LEN);
    end
  endtask

  task automatic test_quiet_stream();
    quiet = 1'b1;
    write_item_count(ITEM_W'($urandom()));
    send_random_traffic(100);
  endtask

  task automatic finish_run();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_words.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_words.size() != 0) begin
      fail_count += pending_words.size();
      $display("%0t missing results: expected %0d more actual 0", $time,
               pending_words.size());
    end
    $display("covered %0d requests of all kinds incl. spare codes, %0d item_count writes",
             words_sent, config_writes);
    $display("runs had mixed kinds, broken framing and fill masks under stalls");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_item_count_masks();
    test_random_runs();
    test_quiet_stream();
    finish_run();
  end

endmodule

FILE: sim.f
src/bwoe_pkg.sv
src/bitset_word_operation_engine_unit.sv
src/bwoe_checker.sv
dv/tb_bitset_word_operation_engine_unit.sv
